// ----- sv/vbfd_pkg.sv -----
// Shared types, constants and helpers of the vehicle bus frame decoder.
// No dependencies; every other file depends on this package.
package vbfd_pkg;

  // Frame buffer sizing
  localparam int MaxFrameBytes = 12;
  localparam int StoreD        = (MaxFrameBytes > 6) ? MaxFrameBytes : 6;
  localparam int IdxW          = $clog2(StoreD);
  localparam int CntW          = $clog2(MaxFrameBytes + 1);
  localparam int MaxPairs      = (MaxFrameBytes - 5) / 2;
  localparam int PairW         = (MaxPairs < 2) ? 1 : $clog2(MaxPairs + 1);

  // Field widths
  localparam int RpmW   = 14;
  localparam int SpeedW = 9;
  localparam int FlagW  = 10;
  localparam int GearW  = 4;
  localparam int LevelW = 4;
  localparam int PrioW  = 3;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  // CRC-8 (SAE J1850)
  localparam logic [7:0] CrcPoly = 8'h1D;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Destination, source and service codes
  localparam logic [7:0] DestRpm   = 8'h1B;
  localparam logic [7:0] DestSpeed = 8'h29;
  localparam logic [7:0] DestMil   = 8'h88;
  localparam logic [7:0] DestSil   = 8'h89;
  localparam logic [7:0] DestTurn  = 8'hDA;
  localparam logic [7:0] DestTrans = 8'h3B;
  localparam logic [7:0] DestTemp  = 8'h49;
  localparam logic [7:0] DestFuel  = 8'h83;
  localparam logic [7:0] DestPoll  = 8'h93;
  localparam logic [7:0] DestOdo   = 8'h69;
  localparam logic [7:0] SrcEcm    = 8'h10;
  localparam logic [7:0] SrcBcm    = 8'h40;
  localparam logic [7:0] SrcIpc    = 8'h61;
  localparam logic [7:0] SvcDtc    = 8'h59;
  localparam logic [7:0] SubTurn   = 8'h39;
  localparam logic [7:0] SubGear   = 8'h03;
  localparam logic [7:0] SubTemp   = 8'h10;
  localparam logic [6:0] SubFuel   = 7'h0A;
  localparam logic [7:0] SubGauge  = 8'h12;
  localparam logic [7:0] SubPoll   = 8'h2A;
  localparam logic [7:0] DtcPwdHi  = 8'h10;
  localparam logic [7:0] DtcPwdLoA = 8'h09;
  localparam logic [7:0] DtcPwdLoB = 8'h10;
  localparam logic [31:0] FuelHiAdd = 32'h0001_0000;

  // Flag bit positions
  localparam int FlMil    = 0;
  localparam int FlMilAux = 1;
  localparam int FlSil    = 2;
  localparam int FlSilAux = 3;
  localparam int FlNeut   = 4;
  localparam int FlEcm    = 5;
  localparam int FlPoll   = 6;
  localparam int FlPwd    = 7;
  localparam int FlBcm    = 8;
  localparam int FlIpc    = 9;

  // Config register indexes (paddr[2])
  localparam logic RegMilMain = 1'b0;
  localparam logic RegSilAux  = 1'b1;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatTooLong  = 2'd1,
    StatCrcBad   = 2'd2,
    StatShortHdr = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StDecode,
    StScan,
    StEmit
  } state_e;

  typedef struct packed {
    logic capture;
    logic decode;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [PairW-1:0] scan_pairs;
  } sts_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/vbfd_if.sv -----
// Handshake channels of the frame decoder: received byte in, snapshot out.
// Depends on vbfd_pkg.
interface vbfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source(output valid, rx_byte, end_of_frame, input ready);
  modport sink(input valid, rx_byte, end_of_frame, output ready);
endinterface

interface vbfd_res_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     frame_status;
  logic [vbfd_pkg::RpmW-1:0]      engine_rpm;
  logic [vbfd_pkg::SpeedW-1:0]    speed_kph;
  logic [vbfd_pkg::FlagW-1:0]     flag_bits;
  logic [1:0]                     turn_state;
  logic [vbfd_pkg::GearW-1:0]     gear_number;
  logic [7:0]                     coolant_temp;
  logic [31:0]                    fuel_tick_total;
  logic [vbfd_pkg::LevelW-1:0]    fuel_level;
  logic [31:0]                    trip_ticks;

  modport source(output valid, frame_status, engine_rpm, speed_kph, flag_bits, turn_state,
                 gear_number, coolant_temp, fuel_tick_total, fuel_level, trip_ticks,
                 input ready);
  modport sink(input valid, frame_status, engine_rpm, speed_kph, flag_bits, turn_state,
               gear_number, coolant_temp, fuel_tick_total, fuel_level, trip_ticks,
               output ready);
endinterface

// ----- sv/vbfd_cfg.sv -----
// APB register file: lamp priority selects for MIL and SIL frames.
// Depends on vbfd_pkg.
module vbfd_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [vbfd_pkg::AddrW-1:0] paddr_i,
  input  logic [vbfd_pkg::DataW-1:0] pwdata_i,
  output logic [vbfd_pkg::DataW-1:0] prdata_o,
  output logic [vbfd_pkg::PrioW-1:0] mil_main_o,
  output logic [vbfd_pkg::PrioW-1:0] sil_aux_o
);
  import vbfd_pkg::*;

  logic             wr_en;
  logic [PrioW-1:0] mil_main_q, mil_main_d;
  logic [PrioW-1:0] sil_aux_q, sil_aux_d;

  assign wr_en = psel_i & penable_i & pwrite_i;

  always_comb begin
    mil_main_d = mil_main_q;
    sil_aux_d  = sil_aux_q;
    if (wr_en) begin
      unique case (paddr_i[2])
        RegMilMain: mil_main_d = pwdata_i[PrioW-1:0];
        RegSilAux:  sil_aux_d  = pwdata_i[PrioW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mil_main_q <= PrioW'(3);
      sil_aux_q  <= PrioW'(7);
    end else begin
      mil_main_q <= mil_main_d;
      sil_aux_q  <= sil_aux_d;
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      RegMilMain: prdata_o = DataW'(mil_main_q);
      RegSilAux:  prdata_o = DataW'(sil_aux_q);
      default:    prdata_o = '0;
    endcase
  end

  assign mil_main_o = mil_main_q;
  assign sil_aux_o  = sil_aux_q;

endmodule

// ----- sv/vbfd_dp.sv -----
// Datapath: frame buffer, CRC, status check, signal decode and DTC pair scan.
// Depends on vbfd_pkg; driven by vbfd_ctrl commands.
module vbfd_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vbfd_pkg::cmd_t              cmd_i,
  output vbfd_pkg::sts_t              sts_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        end_of_frame_i,
  input  logic [vbfd_pkg::PrioW-1:0]  mil_main_i,
  input  logic [vbfd_pkg::PrioW-1:0]  sil_aux_i,
  output logic [1:0]                  frame_status_o,
  output logic [vbfd_pkg::RpmW-1:0]   engine_rpm_o,
  output logic [vbfd_pkg::SpeedW-1:0] speed_kph_o,
  output logic [vbfd_pkg::FlagW-1:0]  flag_bits_o,
  output logic [1:0]                  turn_state_o,
  output logic [vbfd_pkg::GearW-1:0]  gear_number_o,
  output logic [7:0]                  coolant_temp_o,
  output logic [31:0]                 fuel_tick_total_o,
  output logic [vbfd_pkg::LevelW-1:0] fuel_level_o,
  output logic [31:0]                 trip_ticks_o
);
  import vbfd_pkg::*;

  // frame bookkeeping
  logic [7:0]      store_q [StoreD];
  logic [CntW-1:0] cnt_q;
  logic            ovf_q;
  logic [7:0]      crc_q;
  status_e         status_q, status_d;
  logic            full;
  logic [7:0]      hdr_byte;

  // signal state
  logic [RpmW-1:0]   rpm_q, rpm_d;
  logic [SpeedW-1:0] speed_q, speed_d;
  logic [FlagW-1:0]  flags_q, flags_d;
  logic [1:0]        turn_q, turn_d;
  logic [GearW-1:0]  gear_q, gear_d, gear_enc;
  logic [7:0]        temp_q, temp_d;
  logic [31:0]       fuel_q, fuel_d, fuel_add;
  logic [LevelW-1:0] gauge_q, gauge_d;
  logic [31:0]       trip_q, trip_d;
  logic [15:0]       odo_ref_q, odo_ref_d, raw16, odo_delta;
  logic              seeded_q, seeded_d;

  logic [PrioW-1:0] prio;
  logic [7:0]       dest, src, d0, d1, d2, dtc_hi, dtc_lo;
  logic             ok, n_ge5, n_ge6, n_ge7;

  assign full     = (cnt_q == CntW'(MaxFrameBytes));
  assign hdr_byte = (cnt_q == '0) ? rx_byte_i : store_q[0];

  always_comb begin
    priority if (ovf_q || full)       status_d = StatTooLong;
    else if ((~crc_q) != rx_byte_i)   status_d = StatCrcBad;
    else if (hdr_byte[4])             status_d = StatShortHdr;
    else                              status_d = StatOk;
  end

  assign prio   = store_q[0][7:5];
  assign dest   = store_q[1];
  assign src    = store_q[2];
  assign d0     = store_q[3];
  assign d1     = store_q[4];
  assign d2     = store_q[5];
  assign dtc_hi = store_q[4];
  assign dtc_lo = store_q[5];
  assign raw16  = {d1, d2};

  assign ok    = cmd_i.decode && (status_q == StatOk);
  assign n_ge5 = (cnt_q >= CntW'(5));
  assign n_ge6 = (cnt_q >= CntW'(6));
  assign n_ge7 = (cnt_q >= CntW'(7));

  // pairs of trouble codes to walk after the decode cycle
  always_comb begin
    sts_o.scan_pairs = '0;
    if (status_q == StatOk && d0 == SvcDtc && n_ge7) begin
      sts_o.scan_pairs = PairW'((cnt_q - CntW'(5)) >> 1);
    end
  end

  // highest set bit of the gear mask, counted from one
  always_comb begin
    gear_enc = '0;
    for (int k = 0; k < 8; k++) begin
      if (d1[k]) gear_enc = GearW'(k + 1);
    end
  end

  assign fuel_add  = {16'h0000, raw16} + (d0[7] ? FuelHiAdd : 32'h0);
  assign odo_delta = raw16 - odo_ref_q;

  always_comb begin
    rpm_d     = rpm_q;
    speed_d   = speed_q;
    flags_d   = flags_q;
    turn_d    = turn_q;
    gear_d    = gear_q;
    temp_d    = temp_q;
    fuel_d    = fuel_q;
    gauge_d   = gauge_q;
    trip_d    = trip_q;
    odo_ref_d = odo_ref_q;
    seeded_d  = seeded_q;
    if (ok) begin
      if (src == SrcEcm) flags_d[FlEcm] = 1'b1;
      priority if (dest == DestRpm) begin
        if (n_ge7) rpm_d = raw16[15:2];
      end else if (dest == DestSpeed) begin
        if (n_ge7) speed_d = raw16[15:7];
      end else if (dest == DestMil && n_ge5) begin
        if (prio == mil_main_i) flags_d[FlMil] = d0[7];
        else                    flags_d[FlMilAux] = d0[7];
      end else if (dest == DestSil && n_ge5) begin
        if (prio == sil_aux_i)  flags_d[FlSilAux] = d0[7];
        else                    flags_d[FlSil] = d0[7];
      end else if (dest == DestTurn) begin
        if (d0 == SubTurn && n_ge6) turn_d = d1[1:0];
      end else if (dest == DestTrans) begin
        if (src == SrcBcm && n_ge5)      flags_d[FlNeut] = d0[7];
        else if (d0 == SubGear && n_ge6) gear_d = gear_enc;
      end else if (dest == DestTemp) begin
        if (d0 == SubTemp && n_ge6) temp_d = d1;
      end else if (dest == DestFuel) begin
        if (src == SrcEcm) begin
          if (d0[6:0] == SubFuel && n_ge7) fuel_d = fuel_q + fuel_add;
        end else if (src == SrcIpc) begin
          if (d0 == SubGauge && n_ge6) gauge_d = d1[LevelW-1:0];
        end
      end else if (dest == DestPoll && n_ge5) begin
        if (d0 == SubPoll) flags_d[FlPoll] = 1'b1;
      end else if (dest == DestOdo && n_ge7) begin
        if (seeded_q) trip_d = trip_q + {16'h0000, odo_delta};
        seeded_d  = 1'b1;
        odo_ref_d = raw16;
      end
    end
    // one code pair per scan cycle, always read at bytes 4 and 5
    if (cmd_i.scan && (dtc_hi != 8'h00 || dtc_lo != 8'h00)) begin
      if (dtc_hi == DtcPwdHi && (dtc_lo == DtcPwdLoA || dtc_lo == DtcPwdLoB)) begin
        flags_d[FlPwd] = 1'b1;
      end
      if (src == SrcBcm)      flags_d[FlBcm] = 1'b1;
      else if (src == SrcIpc) flags_d[FlIpc] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < StoreD; k++) store_q[k] <= 8'h00;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      crc_q     <= CrcInit;
      status_q  <= StatOk;
      rpm_q     <= '0;
      speed_q   <= '0;
      flags_q   <= '0;
      turn_q    <= '0;
      gear_q    <= '0;
      temp_q    <= '0;
      fuel_q    <= '0;
      gauge_q   <= '0;
      trip_q    <= '0;
      odo_ref_q <= '0;
      seeded_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        if (!full) begin
          store_q[cnt_q[IdxW-1:0]] <= rx_byte_i;
          cnt_q <= cnt_q + CntW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
        if (!end_of_frame_i) crc_q <= crc_update(crc_q, rx_byte_i);
        else                 status_q <= status_d;
      end
      if (cmd_i.scan) begin
        // slide the code pairs down onto bytes 4 and 5
        for (int k = 4; k < StoreD - 2; k++) begin
          store_q[k] <= store_q[k+2];
        end
        store_q[StoreD-2] <= 8'h00;
        store_q[StoreD-1] <= 8'h00;
      end
      if (cmd_i.emit) begin
        for (int k = 0; k < StoreD; k++) store_q[k] <= 8'h00;
        cnt_q <= '0;
        ovf_q <= 1'b0;
        crc_q <= CrcInit;
      end
      rpm_q     <= rpm_d;
      speed_q   <= speed_d;
      flags_q   <= flags_d;
      turn_q    <= turn_d;
      gear_q    <= gear_d;
      temp_q    <= temp_d;
      fuel_q    <= fuel_d;
      gauge_q   <= gauge_d;
      trip_q    <= trip_d;
      odo_ref_q <= odo_ref_d;
      seeded_q  <= seeded_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      frame_status_o    <= status_q;
      engine_rpm_o      <= rpm_q;
      speed_kph_o       <= speed_q;
      flag_bits_o       <= flags_q;
      turn_state_o      <= turn_q;
      gear_number_o     <= gear_q;
      coolant_temp_o    <= temp_q;
      fuel_tick_total_o <= fuel_q;
      fuel_level_o      <= gauge_q;
      trip_ticks_o      <= trip_q;
    end
  end

endmodule

// ----- sv/vbfd_ctrl.sv -----
// Controller: sequences capture, decode, code pair scan and output load.
// Depends on vbfd_pkg; commands vbfd_dp.
module vbfd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rx_valid_i,
  input  logic           rx_eof_i,
  output logic           rx_ready_o,
  input  logic           res_ready_i,
  output logic           res_valid_o,
  input  vbfd_pkg::sts_t sts_i,
  output vbfd_pkg::cmd_t cmd_o
);
  import vbfd_pkg::*;

  state_e           state_q, state_d;
  logic [PairW-1:0] pairs_q, pairs_d;
  logic             res_valid_q, res_valid_d;
  logic             out_free;

  assign out_free = !res_valid_q || res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (rx_valid_i && rx_eof_i) state_d = StDecode;
      StDecode: state_d = (sts_i.scan_pairs != '0) ? StScan : StEmit;
      StScan:   if (pairs_q == PairW'(1)) state_d = StEmit;
      StEmit:   if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    rx_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        rx_ready_o    = 1'b1;
        cmd_o.capture = rx_valid_i;
      end
      StDecode: cmd_o.decode = 1'b1;
      StScan:   cmd_o.scan   = 1'b1;
      StEmit:   cmd_o.emit   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    pairs_d = pairs_q;
    if (state_q == StDecode)    pairs_d = sts_i.scan_pairs;
    else if (state_q == StScan) pairs_d = pairs_q - PairW'(1);
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_o.emit)       res_valid_d = 1'b1;
    else if (res_ready_i) res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pairs_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pairs_q     <= pairs_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;

`ifndef SYNTHESIS
  a_scan_has_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> pairs_q != '0)
    else $error("scan state entered with no code pair left");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q) == StEmit)
    else $error("output word raised outside emit");

  a_no_scan_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDecode && sts_i.scan_pairs == '0) |=> state_q == StEmit)
    else $error("decode without code pairs must go to emit");

  a_last_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_valid_i && rx_ready_o && rx_eof_i) |=> state_q == StDecode)
    else $error("last byte did not start decode");
`endif

endmodule

// ----- sv/vehicle_bus_frame_decoder.sv -----
// Top level of the J1850 VPW frame decoder: APB registers, controller, datapath.
// Depends on vbfd_pkg, vbfd_if, vbfd_cfg, vbfd_dp and vbfd_ctrl.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+-----------------------------------------
//  rx_i     | in  | valid/ready        | rx_byte, end_of_frame
//  res_o    | out | valid/ready        | status + full signal snapshot
//  apb      | in  | psel/penable, rdy=1| priority selects at 0x0 and 0x4
//
// A byte without the end mark is buffered and folded into the CRC.
// After the last byte, the next byte is taken only once capture, decode, P code pair
// scan steps (P = 0..3 for service 0x59 replies) and the load of the output register
// are done; the datapath sets P from the length of the frame.
// A held output word stalls the load step, and the input with it; bytes of the next frame
// are taken while the word waits, up to that frame's own load step.
// Reset is asynchronous, active low; the frame buffer and all signal state clear at once.
module vehicle_bus_frame_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  vbfd_rx_if.sink                    rx_i,
  vbfd_res_if.source                 res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vbfd_pkg::AddrW-1:0] paddr,
  input  logic [vbfd_pkg::DataW-1:0] pwdata,
  output logic [vbfd_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import vbfd_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [PrioW-1:0] mil_main;
  logic [PrioW-1:0] sil_aux;

  // zero-wait-state config port
  assign pready = 1'b1;

  vbfd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .mil_main_o (mil_main),
    .sil_aux_o  (sil_aux)
  );

  // controller owns the handshakes; datapath only sees commands
  vbfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_i.valid),
    .rx_eof_i    (rx_i.end_of_frame),
    .rx_ready_o  (rx_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vbfd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rx_byte_i         (rx_i.rx_byte),
    .end_of_frame_i    (rx_i.end_of_frame),
    .mil_main_i        (mil_main),
    .sil_aux_i         (sil_aux),
    .frame_status_o    (res_o.frame_status),
    .engine_rpm_o      (res_o.engine_rpm),
    .speed_kph_o       (res_o.speed_kph),
    .flag_bits_o       (res_o.flag_bits),
    .turn_state_o      (res_o.turn_state),
    .gear_number_o     (res_o.gear_number),
    .coolant_temp_o    (res_o.coolant_temp),
    .fuel_tick_total_o (res_o.fuel_tick_total),
    .fuel_level_o      (res_o.fuel_level),
    .trip_ticks_o      (res_o.trip_ticks)
  );

endmodule
